// ----- rtl/core/three_wire_spi_register_master_defines.svh -----
// assertion macros shared by the checker of the three-wire serial register master
// no dependencies; the including scope provides clk and rst
`ifndef THREE_WIRE_SPI_REGISTER_MASTER_DEFINES_SVH
`define THREE_WIRE_SPI_REGISTER_MASTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tws_pkg.sv -----
// shared constants, codes and types of the three-wire serial register master
// no dependencies
package tws_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int ADDR_BITS    = 12;
  localparam int DATA_BITS    = 32;
  localparam int HEAD_BITS    = ADDR_BITS + 4;
  localparam int FRAME_BITS   = HEAD_BITS + DATA_BITS;
  localparam int SHIFT_W      = FRAME_BITS + 1;
  localparam int IDX_W        = $clog2(DATA_BITS > HEAD_BITS ? DATA_BITS : HEAD_BITS);
  localparam int CH_W         = 3;
  localparam int CS_W         = 8;
  localparam int REG_ADDR_W   = 12;
  localparam int WDATA_W      = 32;
  localparam int RDATA_W      = 32;
  localparam int HALF_W       = 8;
  localparam int IN_W         = 48;
  localparam int OUT_W        = 48;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [31:0]       BAND_CLEAR_MASK = 32'hFFFE_1FFF;
  localparam logic [HALF_W-1:0] HALF_RESET      = 8'd10;
  localparam logic              BAND_RESET      = 1'b1;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_BAND_MASK   = 1'b1;

  typedef struct packed {
    logic                  req;
    logic                  is_read;
    logic [CH_W-1:0]       channel;
    logic [FRAME_BITS-1:0] word;
    logic                  sdata_in;
  } entry_t;

  typedef struct packed {
    logic               full;
    logic               empty;
  } queue_status_t;

endpackage

// ----- rtl/core/tws_front.sv -----
// front end: takes input words, decodes requests and builds the frame word
// depends on tws_pkg
module tws_front import tws_pkg::*; (
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,
  input  logic [1:0]      s_tuser,
  input  logic            band_mask,
  input  queue_status_t   q_status,
  output logic            push,
  output entry_t          entry
);

  logic [CH_W-1:0]       channel;
  logic [REG_ADDR_W-1:0] reg_addr;
  logic [WDATA_W-1:0]    write_data;
  logic                  is_req;
  logic                  is_read;
  logic [DATA_BITS-1:0]  data;
  logic [HEAD_BITS-1:0]  header;

  assign channel    = s_tdata[CH_W-1:0];
  assign reg_addr   = s_tdata[CH_W +: REG_ADDR_W];
  assign write_data = s_tdata[CH_W + REG_ADDR_W +: WDATA_W];

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    is_read = (s_tuser == OP_READ);
    is_req  = (s_tuser == OP_WRITE || s_tuser == OP_READ) &&
              ({1'b0, channel} < (CH_W + 1)'(NUM_CHANNELS));
    data    = is_read ? '0 : write_data[DATA_BITS-1:0];
    if (!is_read && band_mask && reg_addr[ADDR_BITS-1:0] == '0) begin
      data = data & BAND_CLEAR_MASK[DATA_BITS-1:0];
    end
    header = {reg_addr[ADDR_BITS-1:0], is_read, 3'b000};
    entry.req      = is_req;
    entry.is_read  = is_read;
    entry.channel  = channel;
    entry.word     = {header, data};
    entry.sdata_in = s_tdata[CH_W + REG_ADDR_W + WDATA_W];
  end

endmodule

// ----- rtl/core/tws_queue.sv -----
// short queue between the decode front end and the serial engine
// depends on tws_pkg
module tws_queue import tws_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  entry_t        push_entry,
  input  logic          pop,
  output entry_t        head,
  output queue_status_t status
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/tws_back.sv -----
// serial engine: steps the frame sequencer once per word and registers the result
// depends on tws_pkg
module tws_back import tws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [HALF_W-1:0] half_period,
  input  entry_t           head,
  input  queue_status_t    q_status,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_SETUP = 6'b000010,
    PH_HEAD  = 6'b000100,
    PH_GAP   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_TAIL  = 6'b100000
  } phase_t;

  phase_t               phase, phase_next;
  logic [HALF_W-1:0]    delay_count, delay_count_next;
  logic [IDX_W-1:0]     bit_index, bit_index_next;
  logic [SHIFT_W-1:0]   shift_word, shift_word_next;
  logic [CH_W-1:0]      active_channel, active_channel_next;
  logic                 is_read, is_read_next;
  logic                 clock_level, clock_level_next;
  logic [HALF_W-1:0]    seg_len;
  logic                 sample;
  logic                 done;
  logic [CS_W-1:0]      cs;
  logic                 drive;
  logic [RDATA_W-1:0]   rdata;

  assign pop     = !q_status.empty && (!m_tvalid || m_tready);
  assign seg_len = (half_period == '0) ? HALF_W'(1) : half_period;
  assign sample  = is_read && head.sdata_in;

  always_comb begin
    phase_next          = phase;
    delay_count_next    = delay_count;
    bit_index_next      = bit_index;
    shift_word_next     = shift_word;
    active_channel_next = active_channel;
    is_read_next        = is_read;
    clock_level_next    = clock_level;
    done                = 1'b0;
    if (phase == PH_IDLE) begin
      if (head.req) begin
        is_read_next        = head.is_read;
        active_channel_next = head.channel;
        shift_word_next     = {1'b0, head.word};
        bit_index_next      = '0;
        clock_level_next    = 1'b0;
        delay_count_next    = seg_len;
        phase_next          = PH_SETUP;
      end
    end else if (delay_count > HALF_W'(1)) begin
      delay_count_next = delay_count - 1'b1;
    end else begin
      case (phase)
        PH_SETUP: begin
          phase_next       = PH_HEAD;
          bit_index_next   = '0;
          shift_word_next  = {shift_word[SHIFT_W-2:0], 1'b0};
          clock_level_next = 1'b1;
          delay_count_next = seg_len;
        end
        PH_HEAD, PH_DATA: begin
          if (clock_level) begin
            clock_level_next = 1'b0;
            delay_count_next = seg_len;
          end else if (phase == PH_HEAD) begin
            if (bit_index != IDX_W'(HEAD_BITS - 1)) begin
              bit_index_next   = bit_index + 1'b1;
              shift_word_next  = {shift_word[SHIFT_W-2:0], 1'b0};
              clock_level_next = 1'b1;
              delay_count_next = seg_len;
            end else begin
              phase_next       = PH_GAP;
              delay_count_next = seg_len;
            end
          end else if (bit_index != IDX_W'(DATA_BITS - 1)) begin
            bit_index_next   = bit_index + 1'b1;
            shift_word_next  = {shift_word[SHIFT_W-2:0], sample};
            clock_level_next = 1'b1;
            delay_count_next = seg_len;
          end else begin
            phase_next       = PH_TAIL;
            delay_count_next = seg_len;
          end
        end
        PH_GAP: begin
          phase_next       = PH_DATA;
          bit_index_next   = '0;
          shift_word_next  = {shift_word[SHIFT_W-2:0], sample};
          clock_level_next = 1'b1;
          delay_count_next = seg_len;
        end
        PH_TAIL: begin
          done             = 1'b1;
          phase_next       = PH_IDLE;
          delay_count_next = '0;
          clock_level_next = 1'b0;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cs = '1;
    if (phase_next inside {PH_SETUP, PH_HEAD, PH_GAP, PH_DATA}) begin
      cs[active_channel_next] = 1'b0;
    end
    drive = (phase_next == PH_HEAD) || (phase_next == PH_GAP) ||
            (phase_next == PH_DATA && !is_read_next);
    rdata = (done && is_read) ? RDATA_W'(shift_word[DATA_BITS-1:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      delay_count    <= '0;
      bit_index      <= '0;
      shift_word     <= '0;
      active_channel <= '0;
      is_read        <= 1'b0;
      clock_level    <= 1'b0;
    end else if (pop) begin
      phase          <= phase_next;
      delay_count    <= delay_count_next;
      bit_index      <= bit_index_next;
      shift_word     <= shift_word_next;
      active_channel <= active_channel_next;
      is_read        <= is_read_next;
      clock_level    <= clock_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {4'b0000, rdata, (phase_next != PH_IDLE),
                  drive, drive && shift_word_next[SHIFT_W-1],
                  (phase_next != PH_IDLE) && clock_level_next, cs};
      m_tlast <= done;
    end
  end

endmodule

// ----- rtl/core/three_wire_spi_register_master.sv -----
// three-wire serial register master: an accepted input word is held in the queue, then its
// result word is registered at the back end output; one word in and one word out per cycle
// while m_tready stays high, set by the sequencer stepping once per word in the back end
// synchronous reset empties the queue and output stage, puts the sequencer in idle
// and loads half period 10 and band mask on
// depends on tws_pkg, tws_front, tws_queue, tws_back
module three_wire_spi_register_master import tws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // channel, reg_addr, write_data, sdata_in
  input  logic [1:0]        s_tuser,   // operation
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // chip_selects, serial_clock, sdata_out,
                                       // sdata_drive, busy_res, read_data, zero pad
  output logic              m_tlast,   // frame_done
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [HALF_W-1:0] cfg_data
);

  logic [HALF_W-1:0] half_period;
  logic              band_mask;
  logic              push;
  logic              pop;
  entry_t            push_entry;
  entry_t            head;
  queue_status_t     q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_RESET;
      band_mask   <= BAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period <= cfg_data;
        CFG_BAND_MASK:   band_mask   <= cfg_data[0];
        default:         half_period <= half_period;
      endcase
    end
  end

  tws_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .band_mask (band_mask),
    .q_status  (q_status),
    .push      (push),
    .entry     (push_entry)
  );

  tws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  tws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .half_period (half_period),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

// ----- rtl/core/tws_checker.sv -----
// port-level checks on the result stream of the three-wire serial register master
// depends on tws_pkg and three_wire_spi_register_master_defines.svh; bound to the top level
`include "three_wire_spi_register_master_defines.svh"

module tws_checker import tws_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  `TWS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result word changed while stalled")

  `TWS_ASSERT_NOW(a_released_low, m_tvalid && !m_tdata[10], !m_tdata[9], "data level driven high while released")

  `TWS_ASSERT_NOW(a_idle_quiet, m_tvalid && !m_tdata[11], m_tdata[7:0] == 8'hFF && !m_tdata[8], "select or clock active while idle")

  `TWS_ASSERT_NOW(a_one_select, m_tvalid, $countones(~m_tdata[7:0]) <= 1, "more than one chip select low")

  `TWS_ASSERT_NOW(a_rdata_on_done, m_tvalid && !m_tlast, m_tdata[43:12] == '0, "read data outside frame end")

endmodule

bind three_wire_spi_register_master tws_checker u_tws_checker (.*);

// ----- bench/three_wire_spi_register_master_test.sv -----
// self-checking bench for the three-wire serial register master: drives request and tick words,
// predicts every output word from a per-word model of the frame sequencer and compares
// depends on tws_pkg and the three_wire_spi_register_master rtl
module three_wire_spi_register_master_test;
  import tws_pkg::*;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          SIN_LOW      = 0;
  localparam int          SIN_HIGH     = 1;
  localparam int          SIN_RANDOM   = 2;
  localparam int unsigned RANDOM_WORDS = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          SCLK_BIT     = CS_W;
  localparam int          SDO_BIT      = CS_W + 1;
  localparam int          DRIVE_BIT    = CS_W + 2;
  localparam int          BUSY_BIT     = CS_W + 3;
  localparam int          RDATA_LSB    = CS_W + 4;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_SELECT, SEQ_HEADER, SEQ_GAP, SEQ_DATA, SEQ_TAIL
  } seq_phase_t;

  typedef struct packed {
    logic [CS_W-1:0]    cs;
    logic               sclk;
    logic               sdo;
    logic               drive;
    logic               busy;
    logic               done;
    logic [RDATA_W-1:0] rdata;
  } bus_levels_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;   // channel, reg_addr, write_data, sdata_in
  logic [1:0]        s_tuser;   // operation
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;   // chip_selects, serial_clock, sdata_out,
                                // sdata_drive, busy_res, read_data, zero pad
  logic              m_tlast;   // frame_done
  logic              cfg_we;
  logic              cfg_index;
  logic [HALF_W-1:0] cfg_data;

  // sequencer model state
  seq_phase_t          seq;
  int unsigned         dly;
  int unsigned         bit_idx;
  logic [SHIFT_W-1:0]  shreg;
  logic [CH_W-1:0]     chan;
  logic                rd_frame;
  logic                clk_lvl;
  logic [HALF_W-1:0]   half_ticks;
  logic                band_mask;

  bus_levels_t         expected_levels[$];
  bus_levels_t         want_levels;
  int unsigned         words_sent;
  int unsigned         checked_words;
  int unsigned         mismatch_count;
  int unsigned         burst_left;
  int unsigned         cycle_count;
  int unsigned         hold_requests;
  int unsigned         hold_served;
  int unsigned         hold_left;
  logic [9:0]          stall_cycle;

  three_wire_spi_register_master dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned seg_ticks();
    return (half_ticks == '0) ? 1 : half_ticks;
  endfunction

  function automatic void start_bit(logic sample);
    shreg   = {shreg[SHIFT_W-2:0], sample};
    clk_lvl = 1'b1;
    dly     = seg_ticks();
  endfunction

  function automatic bus_levels_t advance_sequencer(logic [1:0] op, logic [CH_W-1:0] ch,
      logic [REG_ADDR_W-1:0] addr, logic [WDATA_W-1:0] wdata, logic sin);
    bus_levels_t          lv;
    logic [DATA_BITS-1:0] payload;
    lv    = '0;
    lv.cs = '1;
    if (seq == SEQ_IDLE) begin
      if ((op == OP_WRITE || op == OP_READ) && ch < NUM_CHANNELS) begin
        rd_frame = (op == OP_READ);
        chan     = ch;
        payload  = rd_frame ? '0 : wdata;
        if (!rd_frame && band_mask && addr == '0) payload &= BAND_CLEAR_MASK;
        shreg   = {1'b0, addr, rd_frame, 3'b000, payload};
        bit_idx = 0;
        clk_lvl = 1'b0;
        dly     = seg_ticks();
        seq     = SEQ_SELECT;
      end
    end else if (dly > 1) begin
      dly--;
    end else begin
      case (seq)
        SEQ_SELECT: begin
          seq     = SEQ_HEADER;
          bit_idx = 0;
          start_bit(1'b0);
        end
        SEQ_HEADER, SEQ_DATA: begin
          if (clk_lvl) begin
            clk_lvl = 1'b0;
            dly     = seg_ticks();
          end else if (seq == SEQ_HEADER) begin
            if (bit_idx + 1 < HEAD_BITS) begin
              bit_idx++;
              start_bit(1'b0);
            end else begin
              seq = SEQ_GAP;
              dly = seg_ticks();
            end
          end else if (bit_idx + 1 < DATA_BITS) begin
            bit_idx++;
            start_bit(rd_frame & sin);
          end else begin
            seq = SEQ_TAIL;
            dly = seg_ticks();
          end
        end
        SEQ_GAP: begin
          seq     = SEQ_DATA;
          bit_idx = 0;
          start_bit(rd_frame & sin);
        end
        default: begin
          lv.done = 1'b1;
          if (rd_frame) lv.rdata = shreg[DATA_BITS-1:0];
          seq     = SEQ_IDLE;
          dly     = 0;
          clk_lvl = 1'b0;
        end
      endcase
    end
    if (seq >= SEQ_SELECT && seq <= SEQ_DATA) lv.cs[chan] = 1'b0;
    lv.drive = (seq == SEQ_HEADER || seq == SEQ_GAP || (seq == SEQ_DATA && !rd_frame));
    lv.sdo   = lv.drive & shreg[FRAME_BITS];
    lv.sclk  = (seq != SEQ_IDLE) & clk_lvl;
    lv.busy  = (seq != SEQ_IDLE);
    return lv;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("word %0d: %s got %0h want %0h", checked_words, what, got, want);
  endtask

  // sender side, called at a falling edge and returning at one
  task automatic send_word(logic [1:0] op, logic [CH_W-1:0] ch,
      logic [REG_ADDR_W-1:0] addr, logic [WDATA_W-1:0] wdata, logic sin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {sin, wdata, addr, ch};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    expected_levels.push_back(advance_sequencer(op, ch, addr, wdata, sin));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic tick_word(int sin_mode, bit noisy);
    logic [1:0] op;
    logic       sin;
    op  = (noisy && $urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : OP_TICK;
    sin = (sin_mode == SIN_LOW) ? 1'b0 :
          (sin_mode == SIN_HIGH) ? 1'b1 : 1'($urandom_range(0, 1));
    send_word(op, CH_W'($urandom_range(0, 7)), REG_ADDR_W'($urandom), $urandom, sin);
  endtask

  // ticks until the frame ends, or stops just before the tick that ends it when stop_short is set
  task automatic finish_frame(int sin_mode, bit noisy, bit stop_short);
    while (seq != SEQ_IDLE && !(stop_short && seq == SEQ_TAIL && dly <= 1))
      tick_word(sin_mode, noisy);
  endtask

  task automatic drain_pipeline();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_register(logic idx, logic [HALF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HALF_PERIOD) half_ticks = val;
    else band_mask = val[0];
    @(negedge clk);
  endtask

  task automatic test_default_registers();
    // band mask on after reset, frame opens at the reset half period
    send_word(OP_WRITE, CH_W'(7), '0, 32'hFFFF_FFFF, 1'b1);
    repeat (25) tick_word(SIN_RANDOM, 1'b0);
    drain_pipeline();
    load_register(CFG_HALF_PERIOD, HALF_W'(1));
    finish_frame(SIN_RANDOM, 1'b0, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_header_extremes();
    load_register(CFG_HALF_PERIOD, HALF_W'(1));
    send_word(OP_WRITE, '0, '1, 32'hFFFF_FFFF, 1'b0);
    finish_frame(SIN_HIGH, 1'b0, 1'b0);
    drain_pipeline();
    load_register(CFG_BAND_MASK, HALF_W'(0));
    send_word(OP_WRITE, CH_W'(6), '0, 32'hFFFF_FFFF, 1'b0);
    finish_frame(SIN_RANDOM, 1'b0, 1'b0);
    drain_pipeline();
    load_register(CFG_BAND_MASK, HALF_W'(1));
  endtask

  task automatic test_read_sampling();
    send_word(OP_READ, CH_W'(3), '1, '1, 1'b1);
    finish_frame(SIN_RANDOM, 1'b0, 1'b0);
    // unused operation code behaves as a plain tick
    send_word(OP_UNUSED, CH_W'(2), REG_ADDR_W'(1), $urandom, 1'b1);
    send_word(OP_TICK, CH_W'(7), '1, '1, 1'b1);
  endtask

  task automatic test_busy_requests();
    send_word(OP_WRITE, CH_W'(6), REG_ADDR_W'($urandom), $urandom, 1'b0);
    send_word(OP_READ, CH_W'(1), REG_ADDR_W'($urandom), $urandom, 1'b1);
    finish_frame(SIN_RANDOM, 1'b1, 1'b1);
    // a request on the tick that ends the frame is dropped
    send_word(OP_READ, CH_W'(2), REG_ADDR_W'($urandom), $urandom, 1'b1);
    send_word(OP_READ, CH_W'(2), REG_ADDR_W'($urandom), $urandom, 1'b1);
    finish_frame(SIN_RANDOM, 1'b1, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_zero_half_period();
    load_register(CFG_HALF_PERIOD, '0);
    send_word(OP_READ, CH_W'(5), REG_ADDR_W'($urandom), '0, 1'b1);
    finish_frame(SIN_RANDOM, 1'b0, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_half_period_change_mid_frame();
    load_register(CFG_HALF_PERIOD, HALF_W'(1));
    send_word(OP_WRITE, CH_W'(3), REG_ADDR_W'($urandom), $urandom, 1'b0);
    repeat (37) tick_word(SIN_RANDOM, 1'b0);
    drain_pipeline();
    load_register(CFG_HALF_PERIOD, HALF_W'(3));
    repeat (30) tick_word(SIN_RANDOM, 1'b0);
    drain_pipeline();
    load_register(CFG_HALF_PERIOD, HALF_W'(2));
    finish_frame(SIN_RANDOM, 1'b0, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_longest_half_period();
    // the select delay loaded at the longest half period runs out in full
    load_register(CFG_HALF_PERIOD, '1);
    send_word(OP_READ, CH_W'(7), REG_ADDR_W'($urandom), $urandom, 1'b1);
    repeat (100) tick_word(SIN_RANDOM, 1'b1);
    drain_pipeline();
    load_register(CFG_HALF_PERIOD, HALF_W'(1));
    finish_frame(SIN_RANDOM, 1'b1, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_output_backpressure();
    hold_requests++;
    send_word(OP_WRITE, CH_W'(4), REG_ADDR_W'($urandom), $urandom, 1'b0);
    finish_frame(SIN_RANDOM, 1'b0, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_pipeline();
        load_register(CFG_HALF_PERIOD, HALF_W'($urandom_range(1, 2)));
        load_register(CFG_BAND_MASK, HALF_W'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) < 8) begin
        send_word($urandom_range(0, 1) ? OP_READ : OP_WRITE, CH_W'($urandom_range(0, 7)),
                  ($urandom_range(0, 3) == 0) ? '0 : REG_ADDR_W'($urandom), $urandom,
                  1'($urandom_range(0, 1)));
        finish_frame(SIN_RANDOM, 1'($urandom_range(0, 1)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 5)) tick_word(SIN_RANDOM, 1'b1);
      end
    end
  endtask

  // result check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("unexpected word", 64'(m_tdata), '0);
      end else begin
        want_levels = expected_levels.pop_front();
        if (m_tdata[CS_W-1:0] !== want_levels.cs)
          report_mismatch("chip_selects", 64'(m_tdata[CS_W-1:0]), 64'(want_levels.cs));
        if (m_tdata[SCLK_BIT] !== want_levels.sclk)
          report_mismatch("serial_clock", 64'(m_tdata[SCLK_BIT]), 64'(want_levels.sclk));
        if (m_tdata[SDO_BIT] !== want_levels.sdo)
          report_mismatch("sdata_out", 64'(m_tdata[SDO_BIT]), 64'(want_levels.sdo));
        if (m_tdata[DRIVE_BIT] !== want_levels.drive)
          report_mismatch("sdata_drive", 64'(m_tdata[DRIVE_BIT]), 64'(want_levels.drive));
        if (m_tdata[BUSY_BIT] !== want_levels.busy)
          report_mismatch("busy_res", 64'(m_tdata[BUSY_BIT]), 64'(want_levels.busy));
        if (m_tlast !== want_levels.done)
          report_mismatch("frame_done", 64'(m_tlast), 64'(want_levels.done));
        if (m_tdata[RDATA_LSB +: RDATA_W] !== want_levels.rdata)
          report_mismatch("read_data", 64'(m_tdata[RDATA_LSB +: RDATA_W]),
                          64'(want_levels.rdata));
      end
      checked_words++;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      hold_served <= 0;
      hold_left   <= 0;
      stall_cycle <= '0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      m_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1'b1;
      case (stall_cycle[9:8])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= ($urandom_range(0, 3) != 0);
        2'd2: m_tready <= (stall_cycle[2:0] != 3'd5);
        default: m_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("three_wire_spi_register_master: mismatch");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = OP_TICK;
    cfg_we         = 1'b0;
    cfg_index      = CFG_HALF_PERIOD;
    cfg_data       = '0;
    seq            = SEQ_IDLE;
    dly            = 0;
    bit_idx        = 0;
    shreg          = '0;
    chan           = '0;
    rd_frame       = 1'b0;
    clk_lvl        = 1'b0;
    half_ticks     = HALF_RESET;
    band_mask      = BAND_RESET;
    words_sent     = 0;
    burst_left     = 0;
    hold_requests  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_registers();
    test_header_extremes();
    test_read_sampling();
    test_busy_requests();
    test_zero_half_period();
    test_half_period_change_mid_frame();
    test_longest_half_period();
    test_output_backpressure();
    test_random_traffic();
    drain_pipeline();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("three_wire_spi_register_master: match");
    end else begin
      $display("three_wire_spi_register_master: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tws_pkg.sv
rtl/core/tws_front.sv
rtl/core/tws_queue.sv
rtl/core/tws_back.sv
rtl/core/three_wire_spi_register_master.sv
rtl/core/tws_checker.sv
bench/three_wire_spi_register_master_test.sv
